>>> design/ppf_pkg.sv
// Shared types, constants and helpers for the pure pursuit path follower.
package ppf_pkg;

	// Path storage sizing.
	localparam int MAX_POINTS = 256;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	// Stream and configuration widths.
	localparam int IN_DATA_W = 96;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 31;

	// Input command codes carried in tuser.
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_POSE = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd3;

	// Configuration reset values.
	localparam logic [30:0] LOOKAHEAD_RST = 31'd786432;
	localparam logic [30:0] STOP_RST = 31'd131072;
	localparam logic [30:0] TRACK_RST = 31'd786432;
	localparam logic [14:0] LIMIT_RST = 15'd20480;

	// CORDIC setup.
	localparam int CORDIC_STEPS = 14;
	localparam logic signed [17:0] CORDIC_GAIN = 18'sd9949;

	// Controller states.
	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_STOP,
		S_CORDIC,
		S_LOOK_MUL,
		S_LOOK_ADD,
		S_SCAN_GO,
		S_SCAN,
		S_GOAL_RD,
		S_GOAL_DIFF,
		S_NORM,
		S_CURV_SUM,
		S_CURV_CRW,
		S_AB,
		S_MAG,
		S_LIM_MUL,
		S_LIM_CMP,
		S_DIV_A_LD,
		S_DIV_A,
		S_DIV_B_LD,
		S_DIV_B,
		S_RESULT
	} ppf_state_t;

	// Datapath commands, one per cycle.
	typedef enum logic [4:0] {
		DP_NOP,
		DP_CLEAR,
		DP_APPEND,
		DP_LOAD_POSE,
		DP_MARK_DONE,
		DP_STOP_START,
		DP_SET_FINISHED,
		DP_CORDIC_START,
		DP_CORDIC_STEP,
		DP_TRIG,
		DP_LOOK_MUL,
		DP_LOOK_ADD,
		DP_SCAN_START,
		DP_GOAL_ADDR,
		DP_GOAL_DIFF,
		DP_NORM_STEP,
		DP_CURV_MUL,
		DP_CURV_SUM,
		DP_CRW,
		DP_AB,
		DP_MAG,
		DP_LIM_MUL,
		DP_LIM_CMP,
		DP_DIV_LOAD_A,
		DP_DIV_LOAD_B,
		DP_DIV_STEP,
		DP_STORE_A,
		DP_STORE_B,
		DP_EMIT
	} ppf_dp_cmd_t;

	// Status returned by the datapath.
	typedef struct packed {
		logic empty_or_fin;
		logic scan_done;
		logic stop_hit;
		logic cordic_done;
		logic norm_ok;
		logic div_done;
		logic out_free;
	} ppf_status_t;

	// CORDIC angle table in binary angle units.
	function automatic logic [13:0] ppf_cordic_angle(input logic [3:0] i);
		logic [13:0] a;
		case (i)
			4'd0: a = 14'd8192;
			4'd1: a = 14'd4836;
			4'd2: a = 14'd2555;
			4'd3: a = 14'd1297;
			4'd4: a = 14'd651;
			4'd5: a = 14'd326;
			4'd6: a = 14'd163;
			4'd7: a = 14'd81;
			4'd8: a = 14'd41;
			4'd9: a = 14'd20;
			4'd10: a = 14'd10;
			4'd11: a = 14'd5;
			4'd12: a = 14'd3;
			4'd13: a = 14'd1;
			default: a = 14'd0;
		endcase
		return a;
	endfunction

endpackage

>>> design/ppf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> design/ppf_dp.sv
// Datapath of the path follower: path memories, scan pipeline, CORDIC and divider.
module ppf_dp (
	input logic clk,
	input logic arst_n,
	input ppf_pkg::ppf_dp_cmd_t cmd,
	output ppf_pkg::ppf_status_t status,
	input logic [ppf_pkg::IN_DATA_W-1:0] in_data,
	input logic cfg_valid,
	input logic [ppf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ppf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic [ppf_pkg::OUT_DATA_W-1:0] out_data,
	output logic [0:0] out_user
);
	import ppf_pkg::*;

	localparam logic signed [34:0] S32_MAX = 35'sd2147483647;
	localparam logic signed [34:0] S32_MIN = -35'sd2147483648;
	localparam logic signed [17:0] TRIG_MAX = 18'sd16384;
	localparam logic signed [17:0] TRIG_MIN = -18'sd16384;

	// Magnitude of a 33-bit two's complement difference of 32-bit values.
	function automatic logic [31:0] mag33(input logic [32:0] v);
		return v[32] ? (32'd0 - v[31:0]) : v[31:0];
	endfunction

	// Magnitude of a 50-bit two's complement value.
	function automatic logic [48:0] mag50(input logic [49:0] v);
		return v[49] ? (49'd0 - v[48:0]) : v[48:0];
	endfunction

	// Saturate a 35-bit signed sum to 32 bits.
	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		logic [31:0] r;
		if (v > S32_MAX) begin
			r = 32'h7FFF_FFFF;
		end else if (v < S32_MIN) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Clamp a CORDIC output to the Q1.14 unit range.
	function automatic logic signed [15:0] clamp_trig(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > TRIG_MAX) begin
			r = 16'sd16384;
		end else if (v < TRIG_MIN) begin
			r = -16'sd16384;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Input fields.
	logic [31:0] in_x, in_y;
	logic [15:0] in_head, in_speed;

	// Control state.
	logic [CNT_W-1:0] count_q;
	logic finished_q;
	logic full;
	logic [30:0] look_q, stop_q, track_q;
	logic [14:0] limit_q;
	logic scan_run_q, mode_stop_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic v_s1, v_s2, v_s3, v_s4;
	logic issue, scan_done;
	logic [3:0] it_q;
	logic [4:0] dstep_q;
	logic out_valid_q;

	// Memories.
	logic wr_en;
	logic [IDX_W-1:0] xy_rd_addr;
	logic [31:0] ram_x, ram_y;
	logic [15:0] ram_s;

	// Pose and stop threshold.
	logic [31:0] px_q, py_q;
	logic [15:0] head_q;
	logic [61:0] stopsq_q;
	logic res_done_q;

	// Scan pipeline.
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [32:0] dlx, dly, dpx, dpy;
	logic [31:0] mlx_s2, mly_s2, mpx_s2, mpy_s2;
	logic [63:0] sqlx_s3, sqly_s3, sqpx_s3, sqpy_s3;
	logic [64:0] dl_s4, dp_s4;
	logic [64:0] bestl_q, bestp_q;
	logic [IDX_W-1:0] li_q, vi_q;
	logic stop_hit_q;

	// CORDIC and lookahead point.
	logic [1:0] quad_q;
	logic signed [17:0] x_q, y_q, xsh, ysh;
	logic signed [16:0] z_q, ang;
	logic [15:0] t_head;
	logic signed [15:0] xc, yc, c_n, s_n;
	logic signed [15:0] c_q, s_q;
	logic signed [31:0] look_s;
	logic signed [47:0] plc_q, pls_q;
	logic signed [34:0] sumx, sumy;
	logic [31:0] lx_q, ly_q;

	// Goal geometry and drive split.
	logic signed [32:0] dx_q, dy_q;
	logic [30:0] w_q;
	logic [15:0] v_q;
	logic signed [22:0] dx23, dy23;
	logic signed [45:0] sqx_q, sqy_q;
	logic signed [38:0] cdy_q, sdx_q;
	logic [44:0] d2_q, d_q;
	logic signed [39:0] dcross;
	logic signed [25:0] cr_q;
	logic signed [48:0] crw_q;
	logic signed [49:0] a_q, b_q;
	logic [48:0] ma_q, mb_q, m_q;
	logic [15:0] mv_q;
	logic [64:0] vm_q;
	logic [59:0] dld_q;
	logic over_q;

	// Divider.
	logic [64:0] rem_q;
	logic [63:0] dsh_q;
	logic [15:0] q_q;
	logic sgn_q;
	logic [15:0] mul_l;
	logic [48:0] mul_r, den;
	logic div_ge;
	logic [15:0] drive;
	logic [15:0] left_q, right_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [0:0] out_user_q;

	assign in_x = in_data[31:0];
	assign in_y = in_data[63:32];
	assign in_head = in_data[79:64];
	assign in_speed = in_data[95:80];

	assign full = (count_q == CNT_W'(MAX_POINTS));

	// Path count and finished flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			finished_q <= 1'b0;
		end else begin
			case (cmd)
				DP_CLEAR: begin
					count_q <= '0;
					finished_q <= 1'b0;
				end
				DP_APPEND: begin
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
				end
				DP_SET_FINISHED: finished_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q <= LOOKAHEAD_RST;
			stop_q <= STOP_RST;
			track_q <= TRACK_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOOKAHEAD: look_q <= cfg_data;
				REG_STOP: stop_q <= cfg_data;
				REG_TRACK: track_q <= cfg_data;
				REG_LIMIT: limit_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Path memories.
	assign wr_en = (cmd == DP_APPEND) && !full;
	assign xy_rd_addr = (cmd == DP_GOAL_ADDR) ? li_q : rd_idx_q[IDX_W-1:0];

	ppf_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk(clk), .wr_en(wr_en), .wr_addr(count_q[IDX_W-1:0]), .wr_data(in_x),
		.rd_addr(xy_rd_addr), .rd_data(ram_x)
	);

	ppf_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk(clk), .wr_en(wr_en), .wr_addr(count_q[IDX_W-1:0]), .wr_data(in_y),
		.rd_addr(xy_rd_addr), .rd_data(ram_y)
	);

	ppf_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_ram_s (
		.clk(clk), .wr_en(wr_en), .wr_addr(count_q[IDX_W-1:0]), .wr_data(in_speed),
		.rd_addr(vi_q), .rd_data(ram_s)
	);

	// Scan sequencing: one read per cycle from the start index up to the count.
	assign issue = scan_run_q && (rd_idx_q < count_q);
	assign scan_done = scan_run_q && !issue && !v_s1 && !v_s2 && !v_s3 && !v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_run_q <= 1'b0;
			mode_stop_q <= 1'b0;
			rd_idx_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (cmd == DP_STOP_START) begin
				scan_run_q <= 1'b1;
				mode_stop_q <= 1'b1;
				rd_idx_q <= count_q - 1'b1;
			end else if (cmd == DP_SCAN_START) begin
				scan_run_q <= 1'b1;
				mode_stop_q <= 1'b0;
				rd_idx_q <= '0;
			end else begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (scan_done) begin
					scan_run_q <= 1'b0;
				end
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Distances from each stored point to the lookahead point and to the pose.
	assign dlx = {ram_x[31], ram_x} - {lx_q[31], lx_q};
	assign dly = {ram_y[31], ram_y} - {ly_q[31], ly_q};
	assign dpx = {ram_x[31], ram_x} - {px_q[31], px_q};
	assign dpy = {ram_y[31], ram_y} - {py_q[31], py_q};

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		mlx_s2 <= mag33(dlx);
		mly_s2 <= mag33(dly);
		mpx_s2 <= mag33(dpx);
		mpy_s2 <= mag33(dpy);
		sqlx_s3 <= mlx_s2 * mlx_s2;
		sqly_s3 <= mly_s2 * mly_s2;
		sqpx_s3 <= mpx_s2 * mpx_s2;
		sqpy_s3 <= mpy_s2 * mpy_s2;
		dl_s4 <= {1'b0, sqlx_s3} + {1'b0, sqly_s3};
		dp_s4 <= {1'b0, sqpx_s3} + {1'b0, sqpy_s3};
		stopsq_q <= stop_q * stop_q;
	end

	// Stop test or running minimum; the earliest point wins ties.
	always_ff @(posedge clk) begin
		if (v_s4) begin
			if (mode_stop_q) begin
				stop_hit_q <= dp_s4 < {3'b000, stopsq_q};
			end else begin
				if ((idx_s4 == '0) || (dl_s4 < bestl_q)) begin
					bestl_q <= dl_s4;
					li_q <= idx_s4;
				end
				if ((idx_s4 == '0) || (dp_s4 < bestp_q)) begin
					bestp_q <= dp_s4;
					vi_q <= idx_s4;
				end
			end
		end
	end

	// CORDIC step counter and divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
			dstep_q <= '0;
		end else begin
			if (cmd == DP_CORDIC_START) begin
				it_q <= '0;
			end else if (cmd == DP_CORDIC_STEP) begin
				it_q <= it_q + 1'b1;
			end
			if ((cmd == DP_DIV_LOAD_A) || (cmd == DP_DIV_LOAD_B)) begin
				dstep_q <= '0;
			end else if (cmd == DP_DIV_STEP) begin
				dstep_q <= dstep_q + 1'b1;
			end
		end
	end

	// CORDIC rotation helpers and quadrant fold.
	assign t_head = head_q + 16'd8192;
	assign xsh = x_q >>> it_q;
	assign ysh = y_q >>> it_q;
	assign ang = $signed({3'b000, ppf_cordic_angle(it_q)});
	assign xc = clamp_trig(x_q);
	assign yc = clamp_trig(y_q);

	always_comb begin
		case (quad_q)
			2'd0: begin
				c_n = xc;
				s_n = yc;
			end
			2'd1: begin
				c_n = -yc;
				s_n = xc;
			end
			2'd2: begin
				c_n = -xc;
				s_n = -yc;
			end
			default: begin
				c_n = yc;
				s_n = -xc;
			end
		endcase
	end

	// Lookahead point arithmetic.
	assign look_s = $signed({1'b0, look_q});
	assign sumx = $signed({{3{px_q[31]}}, px_q}) + $signed({plc_q[47], plc_q[47:14]});
	assign sumy = $signed({{3{py_q[31]}}, py_q}) + $signed({pls_q[47], pls_q[47:14]});

	// Goal geometry helpers.
	assign dx23 = dx_q[22:0];
	assign dy23 = dy_q[22:0];
	assign dcross = $signed({cdy_q[38], cdy_q}) - $signed({sdx_q[38], sdx_q});

	// Divider operands and step.
	assign mul_l = over_q ? {1'b0, limit_q} : mv_q;
	assign mul_r = (cmd == DP_DIV_LOAD_B) ? mb_q : ma_q;
	assign den = over_q ? m_q : {4'b0000, d_q};
	assign div_ge = ({1'b0, dsh_q} <= rem_q);
	assign drive = sgn_q ? (16'd0 - q_q) : q_q;

	// Sequenced datapath registers.
	always_ff @(posedge clk) begin
		case (cmd)
			DP_LOAD_POSE: begin
				px_q <= in_x;
				py_q <= in_y;
				head_q <= in_head;
				res_done_q <= 1'b0;
			end
			DP_MARK_DONE: res_done_q <= 1'b1;
			DP_SET_FINISHED: res_done_q <= 1'b1;
			DP_CORDIC_START: begin
				quad_q <= t_head[15:14];
				z_q <= $signed({3'b000, t_head[13:0]}) - 17'sd8192;
				x_q <= CORDIC_GAIN;
				y_q <= '0;
			end
			DP_CORDIC_STEP: begin
				if (z_q >= 0) begin
					x_q <= x_q - ysh;
					y_q <= y_q + xsh;
					z_q <= z_q - ang;
				end else begin
					x_q <= x_q + ysh;
					y_q <= y_q - xsh;
					z_q <= z_q + ang;
				end
			end
			DP_TRIG: begin
				c_q <= c_n;
				s_q <= s_n;
			end
			DP_LOOK_MUL: begin
				plc_q <= look_s * c_q;
				pls_q <= look_s * s_q;
			end
			DP_LOOK_ADD: begin
				lx_q <= sat32(sumx);
				ly_q <= sat32(sumy);
			end
			DP_GOAL_DIFF: begin
				dx_q <= {ram_x[31], ram_x} - {px_q[31], px_q};
				dy_q <= {ram_y[31], ram_y} - {py_q[31], py_q};
				w_q <= track_q;
				v_q <= ram_s;
			end
			DP_NORM_STEP: begin
				dx_q <= dx_q >>> 1;
				dy_q <= dy_q >>> 1;
				w_q <= w_q >> 1;
			end
			DP_CURV_MUL: begin
				sqx_q <= dx23 * dx23;
				sqy_q <= dy23 * dy23;
				cdy_q <= c_q * dy23;
				sdx_q <= s_q * dx23;
			end
			DP_CURV_SUM: begin
				d2_q <= {1'b0, sqx_q[43:0]} + {1'b0, sqy_q[43:0]};
				cr_q <= dcross[39:14];
			end
			DP_CRW: crw_q <= cr_q * $signed({1'b0, w_q[21:0]});
			DP_AB: begin
				if (d2_q == '0) begin
					a_q <= 50'sd1;
					b_q <= 50'sd1;
					d_q <= 45'd1;
				end else begin
					a_q <= $signed({5'b00000, d2_q}) - $signed({crw_q[48], crw_q});
					b_q <= $signed({5'b00000, d2_q}) + $signed({crw_q[48], crw_q});
					d_q <= d2_q;
				end
			end
			DP_MAG: begin
				ma_q <= mag50(a_q);
				mb_q <= mag50(b_q);
				m_q <= (mag50(a_q) > mag50(b_q)) ? mag50(a_q) : mag50(b_q);
				mv_q <= v_q[15] ? (16'd0 - v_q) : v_q;
			end
			DP_LIM_MUL: begin
				vm_q <= mv_q * m_q;
				dld_q <= limit_q * d_q;
			end
			DP_LIM_CMP: over_q <= vm_q > {5'b00000, dld_q};
			DP_DIV_LOAD_A, DP_DIV_LOAD_B: begin
				rem_q <= mul_l * mul_r;
				dsh_q <= {den, 15'd0};
				q_q <= '0;
				sgn_q <= v_q[15] ^ ((cmd == DP_DIV_LOAD_B) ? b_q[49] : a_q[49]);
			end
			DP_DIV_STEP: begin
				if (div_ge) begin
					rem_q <= rem_q - {1'b0, dsh_q};
				end
				q_q <= {q_q[14:0], div_ge};
				dsh_q <= dsh_q >> 1;
			end
			DP_STORE_A: left_q <= drive;
			DP_STORE_B: right_q <= drive;
			DP_EMIT: begin
				out_data_q <= res_done_q ? '0 : {right_q, left_q};
				out_user_q <= res_done_q;
			end
			default: ;
		endcase
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd == DP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign out_user = out_user_q;

	// Status toward the controller.
	assign status.empty_or_fin = (count_q == '0) || finished_q;
	assign status.scan_done = scan_done;
	assign status.stop_hit = stop_hit_q;
	assign status.cordic_done = (it_q == 4'(CORDIC_STEPS));
	assign status.norm_ok = (mag33(dx_q) < 32'd4194304) && (mag33(dy_q) < 32'd4194304)
		&& (w_q < 31'd4194304);
	assign status.div_done = (dstep_q == 5'd16);
	assign status.out_free = !out_valid_q || out_ready;

endmodule

>>> design/ppf_ctrl.sv
// Controller state machine that sequences the path follower datapath.
module ppf_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] in_cmd,
	input ppf_pkg::ppf_status_t status,
	output ppf_pkg::ppf_dp_cmd_t cmd
);
	import ppf_pkg::*;

	ppf_state_t state_q, state_n;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && (in_cmd == CMD_POSE)) begin
					state_n = S_CHECK;
				end
			end
			S_CHECK: state_n = status.empty_or_fin ? S_RESULT : S_STOP;
			S_STOP: begin
				if (status.scan_done) begin
					state_n = status.stop_hit ? S_RESULT : S_CORDIC;
				end
			end
			S_CORDIC: begin
				if (status.cordic_done) begin
					state_n = S_LOOK_MUL;
				end
			end
			S_LOOK_MUL: state_n = S_LOOK_ADD;
			S_LOOK_ADD: state_n = S_SCAN_GO;
			S_SCAN_GO: state_n = S_SCAN;
			S_SCAN: begin
				if (status.scan_done) begin
					state_n = S_GOAL_RD;
				end
			end
			S_GOAL_RD: state_n = S_GOAL_DIFF;
			S_GOAL_DIFF: state_n = S_NORM;
			S_NORM: begin
				if (status.norm_ok) begin
					state_n = S_CURV_SUM;
				end
			end
			S_CURV_SUM: state_n = S_CURV_CRW;
			S_CURV_CRW: state_n = S_AB;
			S_AB: state_n = S_MAG;
			S_MAG: state_n = S_LIM_MUL;
			S_LIM_MUL: state_n = S_LIM_CMP;
			S_LIM_CMP: state_n = S_DIV_A_LD;
			S_DIV_A_LD: state_n = S_DIV_A;
			S_DIV_A: begin
				if (status.div_done) begin
					state_n = S_DIV_B_LD;
				end
			end
			S_DIV_B_LD: state_n = S_DIV_B;
			S_DIV_B: begin
				if (status.div_done) begin
					state_n = S_RESULT;
				end
			end
			S_RESULT: begin
				if (status.out_free) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = DP_NOP;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_cmd)
						CMD_CLEAR: cmd = DP_CLEAR;
						CMD_APPEND: cmd = DP_APPEND;
						CMD_POSE: cmd = DP_LOAD_POSE;
						default: cmd = DP_NOP;
					endcase
				end
			end
			S_CHECK: cmd = status.empty_or_fin ? DP_MARK_DONE : DP_STOP_START;
			S_STOP: begin
				if (status.scan_done) begin
					cmd = status.stop_hit ? DP_SET_FINISHED : DP_CORDIC_START;
				end
			end
			S_CORDIC: cmd = status.cordic_done ? DP_TRIG : DP_CORDIC_STEP;
			S_LOOK_MUL: cmd = DP_LOOK_MUL;
			S_LOOK_ADD: cmd = DP_LOOK_ADD;
			S_SCAN_GO: cmd = DP_SCAN_START;
			S_GOAL_RD: cmd = DP_GOAL_ADDR;
			S_GOAL_DIFF: cmd = DP_GOAL_DIFF;
			S_NORM: cmd = status.norm_ok ? DP_CURV_MUL : DP_NORM_STEP;
			S_CURV_SUM: cmd = DP_CURV_SUM;
			S_CURV_CRW: cmd = DP_CRW;
			S_AB: cmd = DP_AB;
			S_MAG: cmd = DP_MAG;
			S_LIM_MUL: cmd = DP_LIM_MUL;
			S_LIM_CMP: cmd = DP_LIM_CMP;
			S_DIV_A_LD: cmd = DP_DIV_LOAD_A;
			S_DIV_A: cmd = status.div_done ? DP_STORE_A : DP_DIV_STEP;
			S_DIV_B_LD: cmd = DP_DIV_LOAD_B;
			S_DIV_B: cmd = status.div_done ? DP_STORE_B : DP_DIV_STEP;
			S_RESULT: begin
				if (status.out_free) begin
					cmd = DP_EMIT;
				end
			end
			default: cmd = DP_NOP;
		endcase
	end

endmodule

>>> design/pure_pursuit_path_follower_core.sv
// Top level of the pure pursuit path follower: stream ports, controller and datapath.
// Clear and append words give no result; an append to a full path is dropped. A pose
// step may wait for the output register to be free. It makes a pass that reads the last
// point for the stop test, runs a 14-step CORDIC for the heading, makes one pass through
// the path memory that reads one point per cycle into a distance pipeline, takes up to
// eleven halving steps on the goal offset, and runs two restoring divisions of 16 steps
// each for the wheel drives. An empty or finished path answers a pose step without these
// steps. The finished result waits in an output register while the next word is taken.
// Configuration writes are accepted in every cycle and are meant to happen while the
// block is idle.
module pure_pursuit_path_follower_core (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// pos_x[31:0], pos_y[63:32], heading_angle[79:64], point_speed[95:80]
	input logic [ppf_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// cmd[1:0]
	input logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// left_drive[15:0], right_drive[31:16]
	output logic [ppf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// done_res[0]
	output logic [0:0] m_axis_tuser,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [ppf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ppf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ppf_pkg::*;

	ppf_dp_cmd_t dp_cmd;
	ppf_status_t dp_status;

	// Register writes never stall.
	assign cfg_ready = 1'b1;

	ppf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_cmd(s_axis_tuser),
		.status(dp_status),
		.cmd(dp_cmd)
	);

	ppf_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(dp_cmd),
		.status(dp_status),
		.in_data(s_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(m_axis_tdata),
		.out_user(m_axis_tuser)
	);

endmodule

>>> bench/tb.sv
// Testbench for the path follower core: random path and pose words against a predictor.
module tb;
	import ppf_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		logic [1:0] cmd;
		logic signed [15:0] spd;
		logic [15:0] hd;
		logic signed [31:0] py;
		logic signed [31:0] px;
	} path_word_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic done;
	} drive_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = CMD_CLEAR;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_LOOKAHEAD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pure_pursuit_path_follower_core u_top (.*);

	// Predictor state and its copy of the registers.
	logic signed [31:0] path_x [MAX_POINTS];
	logic signed [31:0] path_y [MAX_POINTS];
	logic signed [15:0] path_v [MAX_POINTS];
	int path_len;
	bit path_done;
	longint cfg_look, cfg_stop, cfg_track, cfg_limit;

	path_word_t word_q[$];
	drive_res_t drive_q[$];
	int errors = 0;
	int cycles = 0;
	bit idle_send = 1'b1;
	bit idle_recv = 1'b1;
	int send_gap = 0;
	int recv_gap = 0;

	const longint cordic_angle [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
		10, 5, 3, 1};

	initial forever #2 clk = ~clk;

	// Gap lengths: mostly none or short, a few long.
	function automatic int pick_gap(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic longint abs64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [65:0] sq_dist(input longint x1, input longint y1,
			input longint x2, input longint y2);
		logic [65:0] ax, ay;
		ax = 66'(abs64(x1 - x2));
		ay = 66'(abs64(y1 - y2));
		return ax * ax + ay * ay;
	endfunction

	function automatic int nearest_point(input longint qx, input longint qy);
		int best;
		logic [65:0] bd, d;
		best = 0;
		bd = sq_dist(qx, qy, path_x[0], path_y[0]);
		for (int i = 1; i < path_len; i++) begin
			d = sq_dist(qx, qy, path_x[i], path_y[i]);
			if (d < bd) begin
				bd = d;
				best = i;
			end
		end
		return best;
	endfunction

	// Heading to Q1.14 cosine and sine with a quadrant-folded CORDIC.
	task automatic heading_trig(input logic [15:0] hd, output longint c, output longint s);
		logic [15:0] t;
		longint x, y, z, nx;
		t = hd + 16'd8192;
		z = longint'(t[13:0]) - 8192;
		x = 9949;
		y = 0;
		for (int i = 0; i < 14; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= cordic_angle[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += cordic_angle[i];
			end
			x = nx;
		end
		x = x < -16384 ? -16384 : (x > 16384 ? 16384 : x);
		y = y < -16384 ? -16384 : (y > 16384 ? 16384 : y);
		case (t[15:14])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	function automatic longint sat32(input longint v);
		return v < -64'sd2147483648 ? -64'sd2147483648 :
			(v > 64'sd2147483647 ? 64'sd2147483647 : v);
	endfunction

	// Applies one accepted word to the predictor; pose steps queue a drive result.
	task automatic follow_step(input path_word_t w);
		drive_res_t r;
		longint px, py, c, s, lx, ly, v, dx, dy, tw, d2, cr, a, b, dv, m, lim;
		int li, vi;
		px = w.px;
		py = w.py;
		case (w.cmd)
			CMD_CLEAR: begin
				path_len = 0;
				path_done = 1'b0;
			end
			CMD_APPEND: begin
				if (path_len < MAX_POINTS) begin
					path_x[path_len] = w.px;
					path_y[path_len] = w.py;
					path_v[path_len] = w.spd;
					path_len++;
				end
			end
			CMD_POSE: begin
				r = '{left: 16'sd0, right: 16'sd0, done: 1'b1};
				if (path_len != 0 && !path_done) begin
					if (sq_dist(px, py, path_x[path_len-1], path_y[path_len-1]) <
							66'(cfg_stop) * 66'(cfg_stop)) begin
						path_done = 1'b1;
					end else begin
						heading_trig(w.hd, c, s);
						lx = sat32(px + ((cfg_look * c) >>> 14));
						ly = sat32(py + ((cfg_look * s) >>> 14));
						li = nearest_point(lx, ly);
						vi = nearest_point(px, py);
						v = path_v[vi];
						dx = longint'(path_x[li]) - px;
						dy = longint'(path_y[li]) - py;
						tw = cfg_track;
						while (abs64(dx) >= (64'sd1 << 22) || abs64(dy) >= (64'sd1 << 22) ||
								tw >= (64'sd1 << 22)) begin
							dx = dx >>> 1;
							dy = dy >>> 1;
							tw = tw >>> 1;
						end
						d2 = dx * dx + dy * dy;
						if (d2 == 0) begin
							a = 1;
							b = 1;
							dv = 1;
						end else begin
							cr = (c * dy - s * dx) >>> 14;
							a = d2 - cr * tw;
							b = d2 + cr * tw;
							dv = d2;
						end
						m = abs64(a) > abs64(b) ? abs64(a) : abs64(b);
						if (abs64(v) * m > cfg_limit * dv) begin
							lim = v < 0 ? -cfg_limit : cfg_limit;
							r.left = 16'(lim * a / m);
							r.right = 16'(lim * b / m);
						end else begin
							r.left = 16'(v * a / dv);
							r.right = 16'(v * b / dv);
						end
						r.done = 1'b0;
					end
				end
				drive_q = {drive_q, r};
			end
			default: ;
		endcase
	endtask

	// Input driver: predicts each accepted word, then offers the next after a gap.
	always @(posedge clk) begin
		path_word_t w;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				follow_step(path_word_t'({s_axis_tuser, s_axis_tdata}));
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (word_q.size() != 0) begin
					w = word_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= w.cmd;
					s_axis_tdata <= {w.spd, w.hd, w.py, w.px};
					send_gap <= pick_gap(idle_send);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted word with the oldest expected drive.
	always @(posedge clk) begin
		drive_res_t e;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (drive_q.size() == 0) begin
					$error("unexpected result word");
					errors++;
				end else begin
					e = drive_q.pop_front();
					if (m_axis_tdata[15:0] !== e.left) begin
						$error("left_drive expected %0d got %0d", e.left,
							$signed(m_axis_tdata[15:0]));
						errors++;
					end
					if (m_axis_tdata[31:16] !== e.right) begin
						$error("right_drive expected %0d got %0d", e.right,
							$signed(m_axis_tdata[31:16]));
						errors++;
					end
					if (m_axis_tuser[0] !== e.done) begin
						$error("done_res expected %0d got %0d", e.done, m_axis_tuser[0]);
						errors++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				recv_gap <= pick_gap(idle_recv);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAIL pure_pursuit_path_follower_core");
			$finish;
		end
	end

	task automatic add_word(input logic [1:0] cmd, input longint x, input longint y,
			input int hd, input int spd);
		path_word_t w;
		w.cmd = cmd;
		w.px = 32'(x);
		w.py = 32'(y);
		w.hd = 16'(hd);
		w.spd = 16'(spd);
		word_q = {word_q, w};
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		cfg_valid <= 1'b0;
		case (idx)
			REG_LOOKAHEAD: cfg_look = value & 64'h7FFF_FFFF;
			REG_STOP: cfg_stop = value & 64'h7FFF_FFFF;
			REG_TRACK: cfg_track = value & 64'h7FFF_FFFF;
			default: cfg_limit = value & 64'h7FFF;
		endcase
	endtask

	// Lets all queued words go through and every expected drive arrive.
	task automatic drain;
		while (word_q.size() != 0 || s_axis_tvalid || drive_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic longint rand_coord(input longint span);
		return longint'($urandom_range(0, 32'(2 * span))) - span;
	endfunction

	// One path followed by poses around it; some end next to the last point.
	task automatic add_episode;
		int n, k, pi, r;
		longint span, xs[$], ys[$];
		span = $urandom_range(0, 9) == 0 ? (64'sd4000 << 16) : (64'sd150 << 16);
		if ($urandom_range(0, 9) != 0)
			add_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
		r = $urandom_range(0, 199);
		n = r < 2 ? $urandom_range(250, 262) : (r < 180 ? $urandom_range(1, 12) :
			$urandom_range(13, 40));
		for (int i = 0; i < n; i++) begin
			xs = {xs, rand_coord(span)};
			ys = {ys, rand_coord(span)};
			add_word(CMD_APPEND, xs[i], ys[i], $urandom, $urandom_range(0, 9) == 0 ?
				$urandom : int'($urandom_range(0, 12000)) - 3000);
		end
		k = $urandom_range(1, 8);
		for (int j = 0; j < k; j++) begin
			pi = (j == k - 1 && $urandom_range(0, 2) == 0) ? n - 1 :
				$urandom_range(0, n - 1);
			if (pi >= MAX_POINTS)
				pi = MAX_POINTS - 1;
			add_word(CMD_POSE, xs[pi] + rand_coord($urandom_range(0, 3) == 0 ? 64'sd60000 :
				64'sd900000), ys[pi] + rand_coord(64'sd900000), $urandom, $urandom);
		end
	endtask

	task automatic add_random_part(input int count);
		int start;
		start = word_q.size();
		while (word_q.size() - start < count) begin
			if ($urandom_range(0, 9) < 8)
				add_episode();
			else
				add_word(2'($urandom_range(0, 3)), $signed($urandom), $signed($urandom),
					$urandom, $urandom);
		end
	endtask

	initial begin
		cfg_look = LOOKAHEAD_RST;
		cfg_stop = STOP_RST;
		cfg_track = TRACK_RST;
		cfg_limit = LIMIT_RST;
		path_len = 0;
		path_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings.
		add_word(CMD_POSE, 0, 0, 0, 0);
		add_word(CMD_APPEND, -64'sd2147483648, 64'sd2147483647, 0, -32768);
		add_word(CMD_APPEND, 64'sd2147483647, -64'sd2147483648, 65535, 32767);
		add_word(CMD_POSE, 0, 0, 16384, 0);
		add_word(CMD_POSE, -64'sd2147483648, -64'sd2147483648, 65535, 0);
		add_word(CMD_POSE, 64'sd2147483647, 64'sd2147483647, 32768, 0);
		add_word(CMD_UNUSED, 5, 5, 5, 5);
		add_word(CMD_CLEAR, 0, 0, 0, 0);
		// Pose sits on the first point and looks back at it: zero goal distance.
		add_word(CMD_APPEND, 0, 0, 0, 12800);
		add_word(CMD_APPEND, 64'sd1000 << 16, 0, 0, 25600);
		add_word(CMD_POSE, 0, 0, 32768, 0);
		add_word(CMD_POSE, 64'sd10 << 16, 64'sd5 << 16, 0, 0);
		add_word(CMD_POSE, 64'sd10 << 16, -64'sd5 << 16, 49152, 0);
		add_word(CMD_POSE, 64'sd500 << 16, 64'sd3 << 16, 8192, 0);
		// Pose next to the last point latches done, which then sticks.
		add_word(CMD_POSE, (64'sd1000 << 16) + 100, 0, 0, 0);
		add_word(CMD_POSE, 0, 0, 0, 0);
		add_word(CMD_CLEAR, 0, 0, 0, 0);
		add_word(CMD_POSE, 0, 0, 0, 0);
		drain();

		// Full path: appends past capacity are dropped.
		for (int i = 0; i < MAX_POINTS + 4; i++)
			add_word(CMD_APPEND, i << 16, (i % 7) << 16, 0, i * 40);
		add_word(CMD_POSE, 64'sd20 << 16, 64'sd1 << 16, 0, 0);
		add_word(CMD_POSE, 64'sd255 << 16, 64'sd2 << 16, 0, 0);
		drain();

		// Random phases over several register settings, extremes included.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_LOOKAHEAD, LOOKAHEAD_RST);
					write_reg(REG_STOP, STOP_RST);
					write_reg(REG_TRACK, TRACK_RST);
					write_reg(REG_LIMIT, LIMIT_RST);
				end
				1: begin
					write_reg(REG_LOOKAHEAD, 0);
					write_reg(REG_STOP, 0);
					write_reg(REG_TRACK, 0);
					write_reg(REG_LIMIT, 32767);
				end
				2: begin
					write_reg(REG_LOOKAHEAD, 64'h7FFF_FFFF);
					write_reg(REG_TRACK, 64'h7FFF_FFFF);
					write_reg(REG_LIMIT, 1);
				end
				3: begin
					write_reg(REG_STOP, 64'h7FFF_FFFF);
					write_reg(REG_LIMIT, 0);
				end
				4: begin
					write_reg(REG_STOP, 64'sd1 << 16);
					write_reg(REG_LOOKAHEAD, 64'sd30 << 16);
					write_reg(REG_TRACK, 64'sd4 << 16);
					write_reg(REG_LIMIT, 64'sd127 << 8);
				end
				default: begin
					write_reg(REG_LOOKAHEAD, $urandom_range(0, 32'h7FFF_FFFF) >>
						$urandom_range(0, 12));
					write_reg(REG_STOP, $urandom_range(0, 32'h4_0000));
					write_reg(REG_TRACK, $urandom_range(0, 32'h7FFF_FFFF) >>
						$urandom_range(0, 12));
					write_reg(REG_LIMIT, $urandom_range(0, 32767));
				end
			endcase
			idle_send = ph != 5;
			idle_recv = ph != 6;
			add_random_part(90);
			drain();
		end

		if (drive_q.size() != 0) begin
			$error("%0d expected results never arrived", drive_q.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS pure_pursuit_path_follower_core");
		else
			$display("FAIL pure_pursuit_path_follower_core");
		$finish;
	end

endmodule

>>> pure_pursuit_path_follower_core.f
design/ppf_pkg.sv
design/ppf_ram.sv
design/ppf_dp.sv
design/ppf_ctrl.sv
design/pure_pursuit_path_follower_core.sv
bench/tb.sv
